// File: hw/rtl/svfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svfs_pkg;

    localparam int CMD_W   = 4;
    localparam int UP_W    = 6;
    localparam int SLOT_W  = 10;
    localparam int DATA_W  = 64;
    localparam int ERR_W   = 2;
    localparam int DEPTH_W = 7;

    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [ERR_W-1:0] err_t;

    localparam cmd_t CMD_ENTER      = 4'd0;
    localparam cmd_t CMD_EXIT       = 4'd1;
    localparam cmd_t CMD_DEF_HOST   = 4'd2;
    localparam cmd_t CMD_DEF_GLOBAL = 4'd3;
    localparam cmd_t CMD_DEF_LOCAL  = 4'd4;
    localparam cmd_t CMD_GET_HOST   = 4'd5;
    localparam cmd_t CMD_GET_GLOBAL = 4'd6;
    localparam cmd_t CMD_GET_LOCAL  = 4'd7;
    localparam cmd_t CMD_SET_HOST   = 4'd8;
    localparam cmd_t CMD_SET_GLOBAL = 4'd9;
    localparam cmd_t CMD_SET_LOCAL  = 4'd10;
    localparam cmd_t CMD_CLR_HOST   = 4'd11;
    localparam cmd_t CMD_CLR_REST   = 4'd12;

    localparam err_t ERR_OK      = 2'd0;
    localparam err_t ERR_RANGE   = 2'd1;
    localparam err_t ERR_FULL    = 2'd2;
    localparam err_t ERR_NOFRAME = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/scoped_variable_frame_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                               | Handshake
// ----------+---------------------------------------+------------------------------
// command   | command, uplevel, slot, value         | taken when start && !busy
// result    | read_value, error, frame_depth        | valid for one cycle with done
//
// A local get that finds its slot passes through the EXEC and LREAD states: the frame
// base memory is read when the command is accepted, then the local value memory at
// base plus slot in EXEC. Every other command, a failed local get included, returns
// its result from EXEC alone; the memories are read synchronously.
// Reset clears the four counts and the control state; the memories keep their
// contents, and only entries below a count ever reach a result or a count.
// The receiver cannot stall; busy is high from acceptance until done.

module scoped_variable_frame_store #(
    parameter int VALUE_WIDTH  = 64,
    parameter int HOST_DEPTH   = 256,
    parameter int GLOBAL_DEPTH = 256,
    parameter int LOCAL_DEPTH  = 1024,
    parameter int FRAME_DEPTH  = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [svfs_pkg::CMD_W-1:0]  command,
    input  wire logic [svfs_pkg::UP_W-1:0]   uplevel,
    input  wire logic [svfs_pkg::SLOT_W-1:0] slot,
    input  wire logic [svfs_pkg::DATA_W-1:0] value,
    output logic                             done,
    output logic [svfs_pkg::DATA_W-1:0]      read_value,
    output logic [svfs_pkg::ERR_W-1:0]       error,
    output logic [svfs_pkg::DEPTH_W-1:0]     frame_depth
);

    import svfs_pkg::*;

    localparam int HC_W = $clog2(HOST_DEPTH + 1);
    localparam int GC_W = $clog2(GLOBAL_DEPTH + 1);
    localparam int LC_W = $clog2(LOCAL_DEPTH + 1);
    localparam int FC_W = $clog2(FRAME_DEPTH + 1);
    localparam int HA_W = $clog2(HOST_DEPTH);
    localparam int GA_W = $clog2(GLOBAL_DEPTH);
    localparam int LA_W = $clog2(LOCAL_DEPTH);
    localparam int FA_W = $clog2(FRAME_DEPTH);
    localparam int LI_W = $clog2(LOCAL_DEPTH + (1 << SLOT_W));
    localparam int HS_W = (HC_W > SLOT_W) ? HC_W : SLOT_W;
    localparam int GS_W = (GC_W > SLOT_W) ? GC_W : SLOT_W;
    localparam int UC_W = (FC_W > UP_W) ? FC_W : UP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_LREAD = 2'd2;

    logic [VALUE_WIDTH-1:0] host_mem   [HOST_DEPTH];
    logic [VALUE_WIDTH-1:0] global_mem [GLOBAL_DEPTH];
    logic [VALUE_WIDTH-1:0] local_mem  [LOCAL_DEPTH];
    logic [LC_W-1:0]        frame_mem  [FRAME_DEPTH];

    logic [1:0]             state_reg, state_next;
    logic [HC_W-1:0]        host_count_reg, host_count_next;
    logic [GC_W-1:0]        global_count_reg, global_count_next;
    logic [LC_W-1:0]        local_count_reg, local_count_next;
    logic [FC_W-1:0]        frame_count_reg, frame_count_next;

    cmd_t                   cmd_reg;
    logic [UP_W-1:0]        up_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic [VALUE_WIDTH-1:0] host_q, global_q, local_q;
    logic [LC_W-1:0]        frame_q;

    logic                   done_reg, done_next;
    logic [DATA_W-1:0]      rd_reg, rd_next;
    err_t                   err_reg, err_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;

    logic                   accept;
    logic [FA_W-1:0]        frame_raddr;
    logic [LI_W-1:0]        lidx;
    logic                   host_ok, global_ok, local_ok;

    logic                   host_we, global_we, local_we, frame_we;
    logic [HA_W-1:0]        host_waddr;
    logic [GA_W-1:0]        global_waddr;
    logic [LA_W-1:0]        local_waddr;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        if (command == CMD_EXIT)
        begin
            frame_raddr = FA_W'(frame_count_reg - FC_W'(1));
        end
        else
        begin
            frame_raddr = FA_W'(frame_count_reg - FC_W'(1) - FC_W'(uplevel));
        end
    end

    assign lidx      = LI_W'(frame_q) + LI_W'(slot_reg);
    assign host_ok   = HS_W'(slot_reg) < HS_W'(host_count_reg);
    assign global_ok = GS_W'(slot_reg) < GS_W'(global_count_reg);
    assign local_ok  = (UC_W'(up_reg) < UC_W'(frame_count_reg))
                       && (lidx < LI_W'(local_count_reg));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            up_reg    <= uplevel;
            slot_reg  <= slot;
            value_reg <= value[VALUE_WIDTH-1:0];
            host_q    <= host_mem[HA_W'(slot)];
            global_q  <= global_mem[GA_W'(slot)];
            frame_q   <= frame_mem[frame_raddr];
        end
        if (state_reg == ST_EXEC)
        begin
            local_q <= local_mem[LA_W'(lidx)];
        end
        if (host_we)
        begin
            host_mem[host_waddr] <= value_reg;
        end
        if (global_we)
        begin
            global_mem[global_waddr] <= value_reg;
        end
        if (local_we)
        begin
            local_mem[local_waddr] <= value_reg;
        end
        if (frame_we)
        begin
            frame_mem[FA_W'(frame_count_reg)] <= local_count_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        host_count_next   = host_count_reg;
        global_count_next = global_count_reg;
        local_count_next  = local_count_reg;
        frame_count_next  = frame_count_reg;
        done_next         = 1'b0;
        rd_next           = '0;
        err_next          = ERR_OK;
        host_we           = 1'b0;
        global_we         = 1'b0;
        local_we          = 1'b0;
        frame_we          = 1'b0;
        host_waddr        = HA_W'(slot_reg);
        global_waddr      = GA_W'(slot_reg);
        local_waddr       = LA_W'(lidx);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    CMD_ENTER:
                    begin
                        if (frame_count_reg >= FC_W'(FRAME_DEPTH))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            frame_we         = 1'b1;
                            frame_count_next = frame_count_reg + FC_W'(1);
                        end
                    end
                    CMD_EXIT:
                    begin
                        if (frame_count_reg == '0)
                        begin
                            err_next = ERR_NOFRAME;
                        end
                        else
                        begin
                            frame_count_next = frame_count_reg - FC_W'(1);
                            if (frame_q < local_count_reg)
                            begin
                                local_count_next = frame_q;
                            end
                        end
                    end
                    CMD_DEF_HOST:
                    begin
                        if (host_count_reg >= HC_W'(HOST_DEPTH))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            host_we         = 1'b1;
                            host_waddr      = HA_W'(host_count_reg);
                            host_count_next = host_count_reg + HC_W'(1);
                        end
                    end
                    CMD_DEF_GLOBAL:
                    begin
                        if (global_count_reg >= GC_W'(GLOBAL_DEPTH))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            global_we         = 1'b1;
                            global_waddr      = GA_W'(global_count_reg);
                            global_count_next = global_count_reg + GC_W'(1);
                        end
                    end
                    CMD_DEF_LOCAL:
                    begin
                        if (local_count_reg >= LC_W'(LOCAL_DEPTH))
                        begin
                            err_next = ERR_FULL;
                        end
                        else
                        begin
                            local_we         = 1'b1;
                            local_waddr      = LA_W'(local_count_reg);
                            local_count_next = local_count_reg + LC_W'(1);
                        end
                    end
                    CMD_GET_HOST:
                    begin
                        if (host_ok)
                        begin
                            rd_next = DATA_W'(host_q);
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_GET_GLOBAL:
                    begin
                        if (global_ok)
                        begin
                            rd_next = DATA_W'(global_q);
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_GET_LOCAL:
                    begin
                        if (local_ok)
                        begin
                            state_next = ST_LREAD;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_SET_HOST:
                    begin
                        if (host_ok)
                        begin
                            host_we = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_SET_GLOBAL:
                    begin
                        if (global_ok)
                        begin
                            global_we = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_SET_LOCAL:
                    begin
                        if (local_ok)
                        begin
                            local_we = 1'b1;
                        end
                        else
                        begin
                            err_next = ERR_RANGE;
                        end
                    end
                    CMD_CLR_HOST:
                    begin
                        host_count_next = '0;
                    end
                    CMD_CLR_REST:
                    begin
                        global_count_next = '0;
                        local_count_next  = '0;
                        frame_count_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LREAD:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                rd_next    = DATA_W'(local_q);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        depth_next = DEPTH_W'(frame_count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            host_count_reg   <= '0;
            global_count_reg <= '0;
            local_count_reg  <= '0;
            frame_count_reg  <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            host_count_reg   <= host_count_next;
            global_count_reg <= global_count_next;
            local_count_reg  <= local_count_next;
            frame_count_reg  <= frame_count_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            rd_reg    <= rd_next;
            err_reg   <= err_next;
            depth_reg <= depth_next;
        end
    end

    assign done        = done_reg;
    assign read_value  = rd_reg;
    assign error       = err_reg;
    assign frame_depth = depth_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while a transaction is still in progress");

    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_count_reg <= FC_W'(FRAME_DEPTH))
        else $error("frame count beyond frame store depth");

    a_local_bound: assert property (@(posedge clk) disable iff (!rst_n)
        local_count_reg <= LC_W'(LOCAL_DEPTH))
        else $error("local count beyond local store depth");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !done_reg)
        else $error("result strobe in the cycle after a transaction was taken");

endmodule

`default_nettype wire

// File: sim/tb_scoped_variable_frame_store.sv
`timescale 1ns / 1ps

module tb_scoped_variable_frame_store;
    import svfs_pkg::*;

    localparam int HOST_N   = 256;
    localparam int GLOBAL_N = 256;
    localparam int LOCAL_N  = 1024;
    localparam int FRAMES   = 64;

    typedef struct {
        cmd_t              command;
        logic [UP_W-1:0]   uplevel;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] value;
    } frame_cmd_t;

    typedef struct {
        logic [DATA_W-1:0]  read_value;
        err_t               error;
        logic [DEPTH_W-1:0] frame_depth;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [CMD_W-1:0] command = '0;
    logic [UP_W-1:0] uplevel = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [DATA_W-1:0] value = '0;
    logic busy;
    logic done;
    logic [DATA_W-1:0] read_value;
    logic [ERR_W-1:0] error;
    logic [DEPTH_W-1:0] frame_depth;

    scoped_variable_frame_store uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .uplevel     (uplevel),
        .slot        (slot),
        .value       (value),
        .done        (done),
        .read_value  (read_value),
        .error       (error),
        .frame_depth (frame_depth)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [DATA_W-1:0] host_mem [HOST_N];
    logic [DATA_W-1:0] global_mem [GLOBAL_N];
    logic [DATA_W-1:0] local_mem [LOCAL_N];
    int frame_base [FRAMES];
    int host_top = 0;
    int global_top = 0;
    int local_top = 0;
    int frame_top = 0;

    frame_cmd_t command_queue [$];
    frame_result_t pending_results [$];
    frame_result_t oldest_result;
    int accepted_n = 0;
    int checked_n = 0;
    int mismatch_n = 0;
    int outcome_tally [4] = '{0, 0, 0, 0};
    int deepest_nesting = 0;
    int fill_overflow [4] = '{0, 0, 0, 0};

    task automatic queue_item(input frame_cmd_t c);
        command_queue = {command_queue, c};
    endtask

    function automatic bit resolve_local(input int up, input int offset, output int idx);
        idx = 0;
        if (up >= frame_top)
            return 1'b0;
        idx = frame_base[frame_top - 1 - up] + offset;
        return idx < local_top;
    endfunction

    task automatic apply_frame_command(input frame_cmd_t c);
        frame_result_t r;
        int idx;
        r.read_value = '0;
        r.error = ERR_OK;
        case (c.command)
            CMD_ENTER:
                if (frame_top >= FRAMES)
                    r.error = ERR_FULL;
                else
                begin
                    frame_base[frame_top] = local_top;
                    frame_top++;
                end
            CMD_EXIT:
                if (frame_top == 0)
                    r.error = ERR_NOFRAME;
                else
                begin
                    frame_top--;
                    if (frame_base[frame_top] < local_top)
                        local_top = frame_base[frame_top];
                end
            CMD_DEF_HOST:
                if (host_top >= HOST_N)
                    r.error = ERR_FULL;
                else
                begin
                    host_mem[host_top] = c.value;
                    host_top++;
                end
            CMD_DEF_GLOBAL:
                if (global_top >= GLOBAL_N)
                    r.error = ERR_FULL;
                else
                begin
                    global_mem[global_top] = c.value;
                    global_top++;
                end
            CMD_DEF_LOCAL:
                if (local_top >= LOCAL_N)
                    r.error = ERR_FULL;
                else
                begin
                    local_mem[local_top] = c.value;
                    local_top++;
                end
            CMD_GET_HOST:
                if (c.slot < host_top)
                    r.read_value = host_mem[c.slot];
                else
                    r.error = ERR_RANGE;
            CMD_GET_GLOBAL:
                if (c.slot < global_top)
                    r.read_value = global_mem[c.slot];
                else
                    r.error = ERR_RANGE;
            CMD_GET_LOCAL:
                if (resolve_local(int'(c.uplevel), int'(c.slot), idx))
                    r.read_value = local_mem[idx];
                else
                    r.error = ERR_RANGE;
            CMD_SET_HOST:
                if (c.slot < host_top)
                    host_mem[c.slot] = c.value;
                else
                    r.error = ERR_RANGE;
            CMD_SET_GLOBAL:
                if (c.slot < global_top)
                    global_mem[c.slot] = c.value;
                else
                    r.error = ERR_RANGE;
            CMD_SET_LOCAL:
                if (resolve_local(int'(c.uplevel), int'(c.slot), idx))
                    local_mem[idx] = c.value;
                else
                    r.error = ERR_RANGE;
            CMD_CLR_HOST:
                host_top = 0;
            CMD_CLR_REST:
            begin
                global_top = 0;
                local_top = 0;
                frame_top = 0;
            end
            default:
                ;
        endcase
        r.frame_depth = DEPTH_W'(frame_top);
        if (frame_top > deepest_nesting)
            deepest_nesting = frame_top;
        outcome_tally[r.error]++;
        pending_results = {pending_results, r};
    endtask

    function automatic frame_cmd_t random_fields();
        frame_cmd_t c;
        c.command = cmd_t'($urandom_range(0, 15));
        c.uplevel = UP_W'($urandom_range(0, 63));
        c.slot = SLOT_W'($urandom_range(0, 1023));
        c.value = {$urandom, $urandom};
        return c;
    endfunction

    function automatic frame_cmd_t make_cmd(input cmd_t op, input int up, input int s,
                                            input logic [DATA_W-1:0] v);
        frame_cmd_t c;
        c.command = op;
        c.uplevel = UP_W'(up);
        c.slot = SLOT_W'(s);
        c.value = v;
        return c;
    endfunction

    function automatic frame_cmd_t make_access(input frame_cmd_t c, input int kind,
                                               input bit is_set);
        int up;
        int base;
        case (kind)
            0:
            begin
                c.command = is_set ? CMD_SET_HOST : CMD_GET_HOST;
                if (host_top > 0)
                    c.slot = SLOT_W'($urandom_range(0, host_top - 1));
            end
            1:
            begin
                c.command = is_set ? CMD_SET_GLOBAL : CMD_GET_GLOBAL;
                if (global_top > 0)
                    c.slot = SLOT_W'($urandom_range(0, global_top - 1));
            end
            default:
            begin
                c.command = is_set ? CMD_SET_LOCAL : CMD_GET_LOCAL;
                if (frame_top > 0)
                begin
                    up = $urandom_range(0, frame_top - 1);
                    base = frame_base[frame_top - 1 - up];
                    c.uplevel = UP_W'(up);
                    if (local_top > base)
                        c.slot = SLOT_W'($urandom_range(0, local_top - 1 - base));
                end
            end
        endcase
        return c;
    endfunction

    function automatic frame_cmd_t make_bad_access(input frame_cmd_t c, input int kind,
                                                   input bit is_set);
        int up;
        int lo;
        case (kind)
            0:
            begin
                c.command = is_set ? CMD_SET_HOST : CMD_GET_HOST;
                c.slot = SLOT_W'($urandom_range(host_top, 1023));
            end
            1:
            begin
                c.command = is_set ? CMD_SET_GLOBAL : CMD_GET_GLOBAL;
                c.slot = SLOT_W'($urandom_range(global_top, 1023));
            end
            default:
            begin
                c.command = is_set ? CMD_SET_LOCAL : CMD_GET_LOCAL;
                if (frame_top < FRAMES && ($urandom_range(0, 1) == 1 || frame_top == 0))
                    c.uplevel = UP_W'($urandom_range(frame_top, 63));
                else
                begin
                    up = $urandom_range(0, frame_top - 1);
                    c.uplevel = UP_W'(up);
                    lo = local_top - frame_base[frame_top - 1 - up];
                    if (lo < 0)
                        lo = 0;
                    if (lo <= 1023)
                        c.slot = SLOT_W'($urandom_range(lo, 1023));
                end
            end
        endcase
        return c;
    endfunction

    function automatic bit fill_finished();
        return fill_overflow[0] >= 3 && fill_overflow[2] >= 3 && fill_overflow[3] >= 3;
    endfunction

    function automatic frame_cmd_t make_fill_item();
        frame_cmd_t c;
        int wh;
        int wl;
        int we;
        int r;
        c = random_fields();
        if ($urandom_range(0, 99) < 5)
            return make_access(c, int'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        wh = fill_overflow[0] < 3 ? 2 : 0;
        wl = fill_overflow[2] < 3 ? 8 : 0;
        we = fill_overflow[3] < 3 ? 1 : 0;
        r = $urandom_range(0, wh + wl + we - 1);
        if (r < wh)
        begin
            c.command = CMD_DEF_HOST;
            if (host_top >= HOST_N)
                fill_overflow[0]++;
        end
        else if (r < wh + wl)
        begin
            c.command = CMD_DEF_LOCAL;
            if (local_top >= LOCAL_N)
                fill_overflow[2]++;
        end
        else
        begin
            c.command = CMD_ENTER;
            if (frame_top >= FRAMES)
                fill_overflow[3]++;
        end
        return c;
    endfunction

    function automatic frame_cmd_t make_mixed_item();
        frame_cmd_t c;
        int r;
        int kind;
        c = random_fields();
        r = $urandom_range(0, 99);
        kind = $urandom_range(0, 2);
        if (r < 9)
            c.command = CMD_ENTER;
        else if (r < 17)
            c.command = CMD_EXIT;
        else if (r < 41)
        begin
            case ($urandom_range(0, 3))
                0: c.command = CMD_DEF_HOST;
                1: c.command = CMD_DEF_GLOBAL;
                default: c.command = CMD_DEF_LOCAL;
            endcase
        end
        else if (r < 61)
            c = make_access(c, kind, 1'b0);
        else if (r < 74)
            c = make_access(c, kind, 1'b1);
        else if (r < 87)
            ;
        else if (r < 96)
            c = make_bad_access(c, kind, 1'($urandom_range(0, 1)));
        else if (r < 98)
            c.command = CMD_CLR_HOST;
        else
            c.command = CMD_CLR_REST;
        return c;
    endfunction

    function automatic bit take_break();
        if (accepted_n >= 600 && accepted_n < 900)
            return 1'b0;
        return $urandom_range(0, 99) < 28;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                apply_frame_command(command_queue.pop_front());
                accepted_n++;
            end
            if (!start || !busy)
            begin
                if (command_queue.size() != 0 && !take_break())
                begin
                    start <= 1'b1;
                    command <= command_queue[0].command;
                    uplevel <= command_queue[0].uplevel;
                    slot <= command_queue[0].slot;
                    value <= command_queue[0].value;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_n++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing outstanding, read_value", read_value, '0);
            else
            begin
                oldest_result = pending_results.pop_front();
                checked_n++;
                if (read_value !== oldest_result.read_value)
                    report_mismatch("read_value", read_value, oldest_result.read_value);
                if (error !== oldest_result.error)
                    report_mismatch("error", DATA_W'(error), DATA_W'(oldest_result.error));
                if (frame_depth !== oldest_result.frame_depth)
                    report_mismatch("frame_depth", DATA_W'(frame_depth),
                                    DATA_W'(oldest_result.frame_depth));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the store to finish.");
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int random_n;
        int mixed_n;
        int waited;
        frame_result_t leftover;
        random_n = 0;
        mixed_n = 0;
        waited = 0;

        // Short directed run: empty store, extreme values, nested frames, bad opcodes.
        queue_item(make_cmd(CMD_EXIT, 0, 0, '0));
        queue_item(make_cmd(CMD_GET_LOCAL, 0, 0, '0));
        queue_item(make_cmd(CMD_GET_HOST, 0, 0, '0));
        queue_item(make_cmd(CMD_SET_GLOBAL, 0, 0, 64'h1234));
        queue_item(make_cmd(CMD_DEF_HOST, 63, 1023, '1));
        queue_item(make_cmd(CMD_DEF_HOST, 0, 0, '0));
        queue_item(make_cmd(CMD_GET_HOST, 0, 1, '0));
        queue_item(make_cmd(CMD_GET_HOST, 0, 1023, '0));
        queue_item(make_cmd(CMD_SET_HOST, 0, 0, 64'hA5A5_5A5A_C3C3_3C3C));
        queue_item(make_cmd(CMD_GET_HOST, 0, 0, '0));
        queue_item(make_cmd(CMD_DEF_GLOBAL, 0, 0, 64'h8000_0000_0000_0001));
        queue_item(make_cmd(CMD_GET_GLOBAL, 0, 0, '0));
        queue_item(make_cmd(CMD_ENTER, 0, 0, '0));
        queue_item(make_cmd(CMD_DEF_LOCAL, 0, 0, 64'h0123_4567_89AB_CDEF));
        queue_item(make_cmd(CMD_DEF_LOCAL, 0, 0, 64'hFEDC_BA98_7654_3210));
        queue_item(make_cmd(CMD_ENTER, 0, 0, '0));
        queue_item(make_cmd(CMD_DEF_LOCAL, 0, 0, 64'hDEAD_BEEF_0000_FFFF));
        queue_item(make_cmd(CMD_GET_LOCAL, 1, 2, '0));
        queue_item(make_cmd(CMD_SET_LOCAL, 0, 0, 64'h5555_AAAA_5555_AAAA));
        queue_item(make_cmd(CMD_GET_LOCAL, 63, 0, '0));
        queue_item(make_cmd(CMD_GET_LOCAL, 0, 1023, '0));
        queue_item(make_cmd(CMD_EXIT, 0, 0, '0));
        queue_item(make_cmd(CMD_GET_LOCAL, 0, 2, '0));
        queue_item(make_cmd(cmd_t'(CMD_CLR_REST + 1), 63, 1023, '1));
        queue_item(make_cmd(cmd_t'(CMD_CLR_REST + 2), 21, 682, 64'h5555));
        queue_item(make_cmd(cmd_t'(CMD_CLR_REST + 3), 0, 0, '0));
        queue_item(make_cmd(CMD_CLR_HOST, 0, 0, '0));
        queue_item(make_cmd(CMD_CLR_REST, 0, 0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // New items are built only once the previous one is accepted, so they see
        // the exact occupancy of every stack.
        while (!fill_finished())
        begin
            @(negedge clk);
            if (command_queue.size() == 0)
            begin
                queue_item(make_fill_item());
                random_n++;
            end
        end
        while (random_n < 1450 || mixed_n < 100)
        begin
            @(negedge clk);
            if (command_queue.size() == 0)
            begin
                queue_item(make_mixed_item());
                random_n++;
                mixed_n++;
            end
        end

        while (command_queue.size() != 0 || start)
            @(posedge clk);
        while (pending_results.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        while (pending_results.size() != 0)
        begin
            leftover = pending_results.pop_front();
            report_mismatch("missing result, read_value", '0, leftover.read_value);
        end

        $display("%0d transactions accepted and %0d results checked; deepest nesting %0d.",
                 accepted_n, checked_n, deepest_nesting);
        $display("Outcomes: %0d ok, %0d out of range, %0d full, %0d no frame.",
                 outcome_tally[ERR_OK], outcome_tally[ERR_RANGE],
                 outcome_tally[ERR_FULL], outcome_tally[ERR_NOFRAME]);
        if (mismatch_n == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/svfs_pkg.sv
hw/rtl/scoped_variable_frame_store.sv
sim/tb_scoped_variable_frame_store.sv
